FILE: rtl/tpla_pkg.sv
// Shared constants and point/status codes for the trip path length accumulator.
package tpla_pkg;

   localparam int TPLA_COORD_BITS = 24;
   localparam int TPLA_SUM_BITS   = 48;
   localparam int TPLA_COUNT_BITS = 24;

   localparam logic [1:0] OP_START = 2'd1;
   localparam logic [1:0] OP_STOP  = 2'd2;

   localparam logic [1:0] ST_WAIT    = 2'd0;
   localparam logic [1:0] ST_RUN     = 2'd1;
   localparam logic [1:0] ST_STOPPED = 2'd2;
   localparam logic [1:0] ST_AFTER   = 2'd3;

endpackage

FILE: rtl/trip_path_length_accumulator_top.sv
// Trip path length accumulator: sequencer with a shared multiplier, root and divide steps.
//
// Points are ignored until the first START; after that every point adds its step length to
// the path total and its distance from the start to a second sum, and is counted. A STOP
// point also reports the final distance and the average distance to start, after which all
// points are ignored until reset. One transaction is taken at a time. A point of a running
// trip is accepted, then each of its two distances goes through the shared multiplier (dx,
// then dy) and the one-bit-per-cycle square root, then it is accumulated and output. A STOP
// point also passes through the one-bit-per-cycle divider for the average before output.
// Points before start or after stop go straight from accept to output. The result sits in
// an output register, so a new transaction is accepted while the last result is still
// waiting.
module trip_path_length_accumulator_top
   import tpla_pkg::*;
#(
   parameter int COORD_BITS = TPLA_COORD_BITS,
   parameter int SUM_BITS   = TPLA_SUM_BITS,
   parameter int COUNT_BITS = TPLA_COUNT_BITS,
   localparam int REQ_W = ((2 * COORD_BITS + 7) / 8) * 8,
   localparam int RSP_W = ((SUM_BITS + 4 * COORD_BITS + 2 + COUNT_BITS + 7) / 8) * 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   // pos_x, pos_y
   input  logic [REQ_W-1:0] req_tdata,
   // op
   input  logic [1:0]       req_tuser,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   // total_distance, distance_to_start, average_to_start, final_x, final_y, point_count
   output logic [RSP_W-1:0] rsp_tdata,
   // status
   output logic [1:0]       rsp_tuser
);

   localparam int C     = COORD_BITS;
   localparam int M     = 2 * C + 2;
   localparam int RW    = C + 4;
   localparam int WQ    = (SUM_BITS > C + 1) ? SUM_BITS : C + 1;
   localparam int AW    = WQ + 1;
   localparam int CNT_W = $clog2(SUM_BITS + C + 2);

   typedef enum logic [2:0] {
      S_IDLE, S_MUL_X, S_MUL_Y, S_ROOT, S_ACC, S_DIV, S_DONE
   } state_type;

   state_type              state_ff;
   logic                   trip_started_ff, trip_stopped_ff;
   logic                   pass_ff;
   logic [1:0]             op_ff;
   logic [C-1:0]           new_x_ff, new_y_ff;
   logic [C-1:0]           start_x_ff, start_y_ff, last_x_ff, last_y_ff;
   logic [C-1:0]           stop_x_ff, stop_y_ff;
   logic [SUM_BITS-1:0]    path_sum_ff, dist_sum_ff;
   logic [COUNT_BITS-1:0]  count_ff;
   logic [C:0]             step_ff, dist_ff, avg_ff;
   logic [M-1:0]           rad_ff;
   logic [RW-1:0]          rem_ff;
   logic [C:0]             root_ff;
   logic [SUM_BITS-1:0]    dq_ff;
   logic [COUNT_BITS-1:0]  drem_ff;
   logic [CNT_W-1:0]       cnt_ff;
   logic [1:0]             res_status_ff;
   logic                   res_zero_ff;
   logic                   rsp_valid_ff;
   logic [RSP_W-1:0]       rsp_data_ff;
   logic [1:0]             rsp_user_ff;

   // Offset binary makes signed coordinates compare as unsigned ones.
   function automatic logic [C-1:0] abs_diff(input logic [C-1:0] a, input logic [C-1:0] b);
      logic [C-1:0] p, q;
      p = {~a[C-1], a[C-2:0]};
      q = {~b[C-1], b[C-2:0]};
      return (p > q) ? p - q : q - p;
   endfunction

   function automatic logic [SUM_BITS-1:0] sat_add(input logic [SUM_BITS-1:0] s,
                                                   input logic [C:0] d);
      logic [AW-1:0] t;
      t = AW'(s) + AW'(d);
      return (t > AW'({SUM_BITS{1'b1}})) ? {SUM_BITS{1'b1}} : t[SUM_BITS-1:0];
   endfunction

   logic [C-1:0]          op_x, op_y, dx, dy, mul_a;
   logic [2*C-1:0]        prod;
   logic [RW-1:0]         rem_sh, trial, rem_next;
   logic                  root_ge;
   logic [C:0]            root_next;
   logic [COUNT_BITS:0]   drem_sh;
   logic                  div_ge;
   logic [SUM_BITS-1:0]   dq_next;
   logic [WQ-1:0]         quot_ext;
   logic [C:0]            avg_clamped;
   logic [SUM_BITS-1:0]   path_sum_new, dist_sum_new;
   logic [COUNT_BITS-1:0] count_new;
   logic                  out_free;
   logic                  req_fire;

   assign op_x  = pass_ff ? start_x_ff : last_x_ff;
   assign op_y  = pass_ff ? start_y_ff : last_y_ff;
   assign dx    = abs_diff(op_x, new_x_ff);
   assign dy    = abs_diff(op_y, new_y_ff);
   assign mul_a = (state_ff == S_MUL_X) ? dx : dy;
   assign prod  = mul_a * mul_a;

   // Digit-by-digit square root, one result bit per cycle.
   assign rem_sh    = {rem_ff[RW-3:0], rad_ff[M-1:M-2]};
   assign trial     = {1'b0, root_ff, 2'b01};
   assign root_ge   = (rem_sh >= trial);
   assign rem_next  = root_ge ? rem_sh - trial : rem_sh;
   assign root_next = {root_ff[C-1:0], root_ge};

   // Restoring divider, one quotient bit per cycle.
   assign drem_sh     = {drem_ff, dq_ff[SUM_BITS-1]};
   assign div_ge      = (drem_sh >= {1'b0, count_ff});
   assign dq_next     = {dq_ff[SUM_BITS-2:0], div_ge};
   assign quot_ext    = WQ'(dq_next);
   assign avg_clamped = (quot_ext > WQ'({(C + 1){1'b1}})) ? {(C + 1){1'b1}} : quot_ext[C:0];

   assign path_sum_new = sat_add(path_sum_ff, step_ff);
   assign dist_sum_new = sat_add(dist_sum_ff, dist_ff);
   assign count_new    = (count_ff == {COUNT_BITS{1'b1}}) ? count_ff : count_ff + 1'b1;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         trip_started_ff <= 1'b0;
         trip_stopped_ff <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         path_sum_ff     <= '0;
         dist_sum_ff     <= '0;
         count_ff        <= '0;
         stop_x_ff       <= '0;
         stop_y_ff       <= '0;
         dist_ff         <= '0;
         avg_ff          <= '0;
      end else begin
         // In S_DONE the output register is reloaded instead of being emptied.
         if (rsp_valid_ff && rsp_tready && state_ff != S_DONE) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_fire) begin
                  op_ff    <= req_tuser;
                  new_x_ff <= req_tdata[C-1:0];
                  new_y_ff <= req_tdata[2*C-1:C];
                  pass_ff  <= 1'b0;
                  if (trip_stopped_ff) begin
                     res_status_ff <= ST_AFTER;
                     res_zero_ff   <= 1'b0;
                     state_ff      <= S_DONE;
                  end else if (!trip_started_ff) begin
                     res_zero_ff <= 1'b1;
                     if (req_tuser == OP_START) begin
                        start_x_ff      <= req_tdata[C-1:0];
                        start_y_ff      <= req_tdata[2*C-1:C];
                        last_x_ff       <= req_tdata[C-1:0];
                        last_y_ff       <= req_tdata[2*C-1:C];
                        trip_started_ff <= 1'b1;
                        res_status_ff   <= ST_RUN;
                     end else begin
                        res_status_ff <= ST_WAIT;
                     end
                     state_ff <= S_DONE;
                  end else begin
                     state_ff <= S_MUL_X;
                  end
               end
            end
            S_MUL_X: begin
               rad_ff   <= M'(prod);
               rem_ff   <= '0;
               root_ff  <= '0;
               cnt_ff   <= CNT_W'(C);
               state_ff <= S_MUL_Y;
            end
            S_MUL_Y: begin
               rad_ff   <= rad_ff + M'(prod);
               state_ff <= S_ROOT;
            end
            S_ROOT: begin
               rem_ff  <= rem_next;
               root_ff <= root_next;
               rad_ff  <= {rad_ff[M-3:0], 2'b00};
               cnt_ff  <= cnt_ff - 1'b1;
               if (cnt_ff == '0) begin
                  // First pass measures the step, second the distance from start.
                  if (!pass_ff) begin
                     step_ff  <= root_next;
                     pass_ff  <= 1'b1;
                     state_ff <= S_MUL_X;
                  end else begin
                     dist_ff  <= root_next;
                     state_ff <= S_ACC;
                  end
               end
            end
            S_ACC: begin
               path_sum_ff <= path_sum_new;
               dist_sum_ff <= dist_sum_new;
               count_ff    <= count_new;
               last_x_ff   <= new_x_ff;
               last_y_ff   <= new_y_ff;
               res_zero_ff <= 1'b0;
               if (op_ff == OP_STOP) begin
                  stop_x_ff       <= new_x_ff;
                  stop_y_ff       <= new_y_ff;
                  trip_stopped_ff <= 1'b1;
                  res_status_ff   <= ST_STOPPED;
                  dq_ff           <= dist_sum_new;
                  drem_ff         <= '0;
                  cnt_ff          <= CNT_W'(SUM_BITS - 1);
                  state_ff        <= S_DIV;
               end else begin
                  res_status_ff <= ST_RUN;
                  state_ff      <= S_DONE;
               end
            end
            S_DIV: begin
               dq_ff   <= dq_next;
               drem_ff <= div_ge ? COUNT_BITS'(drem_sh - {1'b0, count_ff})
                                 : drem_sh[COUNT_BITS-1:0];
               cnt_ff  <= cnt_ff - 1'b1;
               if (cnt_ff == '0) begin
                  avg_ff   <= avg_clamped;
                  state_ff <= S_DONE;
               end
            end
            S_DONE: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_user_ff  <= res_status_ff;
                  if (res_zero_ff) begin
                     rsp_data_ff <= '0;
                  end else if (res_status_ff == ST_RUN) begin
                     rsp_data_ff <= RSP_W'({count_ff, {(2 * C){1'b0}}, {(C + 1){1'b0}},
                                            dist_ff, path_sum_ff});
                  end else begin
                     rsp_data_ff <= RSP_W'({count_ff, stop_y_ff, stop_x_ff, avg_ff,
                                            dist_ff, path_sum_ff});
                  end
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // A trip can only stop after it started, and the stop point is always counted.
   a_stop_after_start: assert property (@(posedge clock) disable iff (reset)
      trip_stopped_ff |-> trip_started_ff)
      else $error("trip stopped without a start");

   a_stop_sticky: assert property (@(posedge clock) disable iff (reset)
      trip_stopped_ff |=> trip_stopped_ff)
      else $error("stopped trip left the stopped state");

   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> (count_ff != '0))
      else $error("average divider started with a zero count");

   a_stop_counted: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_user_ff == ST_STOPPED || rsp_user_ff == ST_AFTER))
         |-> (count_ff != '0))
      else $error("stop result with zero point count");

endmodule

FILE: sim/trip_path_length_accumulator_top_tb.sv
// Self-checking stream testbench for the trip path length accumulator.
`timescale 1ns / 100ps

module trip_path_length_accumulator_top_tb;
   import tpla_pkg::*;

   localparam int CW = TPLA_COORD_BITS;
   localparam int SW = TPLA_SUM_BITS;
   localparam int NW = TPLA_COUNT_BITS;
   localparam int REQ_W = ((2 * CW + 7) / 8) * 8;
   localparam int RSP_W = ((SW + 4 * CW + 2 + NW + 7) / 8) * 8;

   // Field offsets inside rsp_tdata, lowest field first.
   localparam int TOT_LO  = 0;
   localparam int DIST_LO = SW;
   localparam int AVG_LO  = DIST_LO + CW + 1;
   localparam int FX_LO   = AVG_LO + CW + 1;
   localparam int FY_LO   = FX_LO + CW;
   localparam int CNT_LO  = FY_LO + CW;

   localparam logic [1:0] OP_PLAIN = 2'd0;
   localparam logic [1:0] OP_SPARE = 2'd3;

   localparam logic [CW-1:0] COORD_MAX = {1'b0, {(CW-1){1'b1}}};
   localparam logic [CW-1:0] COORD_MIN = {1'b1, {(CW-1){1'b0}}};
   localparam logic [CW-1:0] ORIGIN_X  = COORD_MIN;
   localparam logic [CW-1:0] ORIGIN_Y  = COORD_MAX;

   localparam int MAX_WAIT       = 13;
   localparam int RUN_POINTS     = 570;
   localparam int AFTER_POINTS   = 12;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int DRAIN_CYCLES   = 200;

   typedef logic signed [CW-1:0] coord_type;

   typedef struct packed {
      logic [1:0]    status;
      logic [SW-1:0] total;
      logic [CW:0]   to_start;
      logic [CW:0]   avg;
      logic [CW-1:0] fx;
      logic [CW-1:0] fy;
      logic [NW-1:0] count;
   } trip_result_type;

   // A row either carries its expected status (all other fields zero) or is predicted.
   typedef struct packed {
      logic [1:0]    op;
      logic [CW-1:0] x;
      logic [CW-1:0] y;
      logic          typed;
      logic [1:0]    status;
   } point_row_type;

   localparam point_row_type DIRECTED_ROWS [14] = '{
      '{OP_PLAIN, COORD_MAX, COORD_MAX, 1'b1, ST_WAIT},
      '{OP_STOP,  COORD_MIN, COORD_MIN, 1'b1, ST_WAIT},
      '{OP_SPARE, 24'hFFFFFF, 24'h000000, 1'b1, ST_WAIT},
      '{OP_PLAIN, 24'h000000, 24'h000000, 1'b1, ST_WAIT},
      '{OP_START, ORIGIN_X, ORIGIN_Y, 1'b1, ST_RUN},
      '{OP_PLAIN, COORD_MAX, COORD_MIN, 1'b0, ST_RUN},
      '{OP_PLAIN, COORD_MAX, COORD_MIN, 1'b0, ST_RUN},
      '{OP_START, 24'h000000, 24'h000000, 1'b0, ST_RUN},
      '{OP_SPARE, COORD_MAX, COORD_MAX, 1'b0, ST_RUN},
      '{OP_PLAIN, COORD_MIN, COORD_MIN, 1'b0, ST_RUN},
      '{OP_PLAIN, 24'h000001, 24'hFFFFFF, 1'b0, ST_RUN},
      '{OP_PLAIN, 24'hFFFFFF, 24'h000001, 1'b0, ST_RUN},
      '{OP_PLAIN, ORIGIN_X, ORIGIN_Y, 1'b0, ST_RUN},
      '{OP_PLAIN, 24'h000100, 24'h000000, 1'b0, ST_RUN}
   };

   logic             clock;
   logic             reset      = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata  = '0;
   logic [1:0]       req_tuser  = '0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;
   logic [1:0]       rsp_tuser;

   trip_path_length_accumulator_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // Trip state as the predictor sees it.
   bit            trip_on;
   bit            trip_done;
   coord_type     origin_x, origin_y;
   coord_type     prev_x, prev_y;
   coord_type     stop_x, stop_y;
   logic [SW-1:0] path_total   = '0;
   logic [SW-1:0] radial_total = '0;
   logic [NW-1:0] counted      = '0;

   trip_result_type pending_results[$];
   int              faults;
   int              idle_cycles;
   bit              no_idle;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int draw_wait();
      return no_idle ? 0 : $urandom_range(0, MAX_WAIT);
   endfunction

   // Floor of the Euclidean distance, found one root bit at a time.
   function automatic logic [CW:0] floor_dist(coord_type ax, coord_type ay,
                                              coord_type bx, coord_type by);
      longint          dx;
      longint          dy;
      longint unsigned square;
      longint unsigned root;
      longint unsigned trial;
      dx = longint'(ax) - longint'(bx);
      dy = longint'(ay) - longint'(by);
      if (dx < 0) dx = -dx;
      if (dy < 0) dy = -dy;
      square = dx * dx + dy * dy;
      root = 0;
      for (int b = CW; b >= 0; b--) begin
         trial = root | (64'd1 << b);
         if (trial * trial <= square) root = trial;
      end
      return root[CW:0];
   endfunction

   function automatic logic [SW-1:0] sat_add(logic [SW-1:0] acc, logic [CW:0] d);
      logic [SW:0] s;
      s = {1'b0, acc} + d;
      return s[SW] ? {SW{1'b1}} : s[SW-1:0];
   endfunction

   function automatic trip_result_type stop_report(logic [1:0] status);
      trip_result_type res;
      longint unsigned mean;
      res = '0;
      res.status   = status;
      res.total    = path_total;
      res.to_start = floor_dist(origin_x, origin_y, stop_x, stop_y);
      mean = (counted == 0) ? 0 : longint'(radial_total) / longint'(counted);
      res.avg      = (mean > {(CW+1){1'b1}}) ? {(CW+1){1'b1}} : mean[CW:0];
      res.fx       = stop_x;
      res.fy       = stop_y;
      res.count    = counted;
      return res;
   endfunction

   task automatic trip_step(input logic [1:0] op, input coord_type x, input coord_type y,
                            output trip_result_type res);
      logic [CW:0] leg;
      logic [CW:0] radial;
      res = '0;
      if (trip_done) begin
         res = stop_report(ST_AFTER);
      end else if (!trip_on) begin
         res.status = ST_WAIT;
         if (op == OP_START) begin
            origin_x = x;
            origin_y = y;
            prev_x   = x;
            prev_y   = y;
            trip_on  = 1'b1;
            res.status = ST_RUN;
         end
      end else begin
         leg    = floor_dist(prev_x, prev_y, x, y);
         radial = floor_dist(origin_x, origin_y, x, y);
         path_total   = sat_add(path_total, leg);
         radial_total = sat_add(radial_total, radial);
         prev_x = x;
         prev_y = y;
         if (counted != {NW{1'b1}}) counted++;
         if (op == OP_STOP) begin
            stop_x    = x;
            stop_y    = y;
            trip_done = 1'b1;
            res = stop_report(ST_STOPPED);
         end else begin
            res.status   = ST_RUN;
            res.total    = path_total;
            res.to_start = radial;
            res.count    = counted;
         end
      end
   endtask

   task automatic send_point(input logic [1:0] op, input coord_type x, input coord_type y,
                             input logic typed, input logic [1:0] typed_status);
      int              gap;
      trip_result_type predicted;
      gap = draw_wait();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {y, x};
      do @(posedge clock); while (req_tready !== 1'b1);
      trip_step(op, x, y, predicted);
      if (typed) begin
         predicted = '0;
         predicted.status = typed_status;
      end
      pending_results.push_back(predicted);
   endtask

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] seen);
      if (want !== seen) begin
         $error("%s: expected %0h, got %0h", name, want, seen);
         faults++;
      end
   endtask

   task automatic check_result(input trip_result_type got);
      trip_result_type want;
      if (pending_results.size() == 0) begin
         $error("result transaction arrived with no expectation pending");
         faults++;
      end else begin
         want = pending_results.pop_front();
         check_field("status", want.status, got.status);
         check_field("total_distance", want.total, got.total);
         check_field("distance_to_start", want.to_start, got.to_start);
         check_field("average_to_start", want.avg, got.avg);
         check_field("final_x", want.fx, got.fx);
         check_field("final_y", want.fy, got.fy);
         check_field("point_count", want.count, got.count);
      end
   endtask

   // Result side: random backpressure per transaction.
   initial begin
      int              stall;
      trip_result_type got;
      while (reset) @(posedge clock);
      forever begin
         stall = draw_wait();
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (rsp_tvalid !== 1'b1);
         got.status   = rsp_tuser;
         got.total    = rsp_tdata[TOT_LO +: SW];
         got.to_start = rsp_tdata[DIST_LO +: CW + 1];
         got.avg      = rsp_tdata[AVG_LO +: CW + 1];
         got.fx       = rsp_tdata[FX_LO +: CW];
         got.fy       = rsp_tdata[FY_LO +: CW];
         got.count    = rsp_tdata[CNT_LO +: NW];
         check_result(got);
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else if (((req_tvalid && req_tready) === 1'b1) ||
                   ((rsp_tvalid && rsp_tready) === 1'b1)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("** trip_path_length_accumulator_top: FAILED **");
            $finish;
         end
      end
   end

   initial begin
      coord_type  px;
      coord_type  py;
      coord_type  nx;
      coord_type  ny;
      logic [1:0] op;
      int         pick;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED_ROWS[i]) begin
         send_point(DIRECTED_ROWS[i].op, DIRECTED_ROWS[i].x, DIRECTED_ROWS[i].y,
                    DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].status);
      end

      // Running trip: mostly plain points, with repeated START and the spare tag mixed in.
      px = DIRECTED_ROWS[13].x;
      py = DIRECTED_ROWS[13].y;
      for (int n = 0; n < RUN_POINTS; n++) begin
         if (n % 50 == 0) no_idle = ($urandom_range(0, 3) == 0);
         pick = $urandom_range(0, 19);
         op = (pick == 0) ? OP_START : (pick == 1) ? OP_SPARE : OP_PLAIN;
         pick = $urandom_range(0, 9);
         if (pick <= 3) begin
            nx = px + coord_type'($urandom_range(0, 2047)) - coord_type'(1024);
            ny = py + coord_type'($urandom_range(0, 2047)) - coord_type'(1024);
         end else if (pick <= 6) begin
            nx = coord_type'($urandom());
            ny = coord_type'($urandom());
         end else if (pick == 7) begin
            nx = $urandom_range(0, 1) ? COORD_MAX : COORD_MIN;
            ny = $urandom_range(0, 1) ? COORD_MAX : COORD_MIN;
         end else if (pick == 8) begin
            nx = coord_type'(ORIGIN_X) + coord_type'($urandom_range(0, 255));
            ny = coord_type'(ORIGIN_Y) - coord_type'($urandom_range(0, 255));
         end else begin
            nx = px;
            ny = py;
         end
         send_point(op, nx, ny, 1'b0, ST_RUN);
         px = nx;
         py = ny;
      end

      no_idle = 1'b0;
      send_point(OP_STOP, coord_type'($urandom()), coord_type'($urandom()), 1'b0, ST_STOPPED);
      // Everything after the stop point is ignored, whatever its tag.
      for (int n = 0; n < AFTER_POINTS; n++) begin
         op = 2'($urandom_range(0, 3));
         send_point(op, coord_type'($urandom()), coord_type'($urandom()), 1'b0, ST_AFTER);
      end
      req_tvalid <= 1'b0;

      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (faults == 0) begin
         $display("** trip_path_length_accumulator_top: PASSED **");
      end else begin
         $display("** trip_path_length_accumulator_top: FAILED **");
      end
      $finish;
   end

endmodule

FILE: files.f
rtl/tpla_pkg.sv
rtl/trip_path_length_accumulator_top.sv
sim/trip_path_length_accumulator_top_tb.sv
